### sv/nfp_pkg.sv
`default_nettype none

package nfp_pkg;

   localparam int unsigned DVD_W = 56;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic [31:0]        Q_ONE   = 32'h0100_0000;

   localparam logic [23:0] COLOR_RED  = 24'hFF0000;
   localparam logic [23:0] COLOR_NEG  = 24'hABBDFF;
   localparam logic [23:0] COLOR_PP   = 24'h894B77;
   localparam logic [23:0] COLOR_PN   = 24'h99E1D9;
   localparam logic [23:0] COLOR_MID  = 24'hA2DCC7;
   localparam logic [31:0] MID_DIV    = 32'd1000000;

   localparam logic [5:0]  PC_LOOP    = 6'd7;
   localparam logic [5:0]  PC_TAIL    = 6'd33;
   localparam logic [5:0]  PC_SMALL   = 6'd41;
   localparam logic [5:0]  PC_COLOR   = 6'd49;

   typedef struct packed {
      logic [9:0] px_x;
      logic [9:0] px_y;
   } req_type;

   typedef struct packed {
      logic [23:0] color;
      logic [7:0]  iterations;
   } rsp_type;

   typedef enum logic [3:0] {
      R_X, R_Y, R_OX, R_OY, R_WR, R_WI, R_NR, R_NI,
      R_DR, R_DI, R_R, R_DEN, R_T0, R_T1, R_S
   } reg_type;

   typedef enum logic [2:0] {
      B_REG, B_ZERO, B_ZOOM, B_ASPECT, B_MOVEX, B_MOVEY
   } bsel_type;

   typedef enum logic [3:0] {
      OP_MUL, OP_ADD, OP_SUB, OP_DBL1, OP_TRI, OP_DIV,
      OP_MAPX, OP_MAPY, OP_COLOR, OP_CHECK, OP_BRANCH, OP_JUMP
   } op_type;

   typedef struct packed {
      op_type     op;
      reg_type    dst;
      reg_type    a;
      reg_type    b;
      bsel_type   bsel;
      logic [5:0] target;
   } uop_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [31:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic signed [31:0] sat(input logic signed [65:0] v);
      if (v > 66'(S32_MAX)) return S32_MAX;
      if (v < 66'(S32_MIN)) return S32_MIN;
      return signed'(v[31:0]);
   endfunction

   function automatic uop_type mk(input op_type op, input reg_type dst, input reg_type a,
                                  input reg_type b, input bsel_type bsel,
                                  input logic [5:0] target);
      uop_type u;
      u.op     = op;
      u.dst    = dst;
      u.a      = a;
      u.b      = b;
      u.bsel   = bsel;
      u.target = target;
      return u;
   endfunction

   // microprogram: view mapping, Newton loop (Smith division), final color
   function automatic uop_type ucode(input logic [5:0] pc);
      uop_type u;
      unique case (pc)
         6'd0:  u = mk(OP_MAPX,   R_X,   R_X,   R_X,   B_REG,    6'd0);
         6'd1:  u = mk(OP_MUL,    R_X,   R_X,   R_X,   B_ZOOM,   6'd0);
         6'd2:  u = mk(OP_MUL,    R_X,   R_X,   R_X,   B_ASPECT, 6'd0);
         6'd3:  u = mk(OP_ADD,    R_X,   R_X,   R_X,   B_MOVEX,  6'd0);
         6'd4:  u = mk(OP_MAPY,   R_Y,   R_Y,   R_Y,   B_REG,    6'd0);
         6'd5:  u = mk(OP_MUL,    R_Y,   R_Y,   R_Y,   B_ZOOM,   6'd0);
         6'd6:  u = mk(OP_ADD,    R_Y,   R_Y,   R_Y,   B_MOVEY,  6'd0);
         6'd7:  u = mk(OP_CHECK,  R_X,   R_X,   R_X,   B_REG,    PC_COLOR);
         6'd8:  u = mk(OP_ADD,    R_OX,  R_X,   R_X,   B_ZERO,   6'd0);
         6'd9:  u = mk(OP_ADD,    R_OY,  R_Y,   R_Y,   B_ZERO,   6'd0);
         6'd10: u = mk(OP_MUL,    R_T0,  R_X,   R_X,   B_REG,    6'd0);
         6'd11: u = mk(OP_MUL,    R_T1,  R_Y,   R_Y,   B_REG,    6'd0);
         6'd12: u = mk(OP_SUB,    R_WR,  R_T0,  R_T1,  B_REG,    6'd0);
         6'd13: u = mk(OP_MUL,    R_T0,  R_X,   R_Y,   B_REG,    6'd0);
         6'd14: u = mk(OP_ADD,    R_WI,  R_T0,  R_T0,  B_REG,    6'd0);
         6'd15: u = mk(OP_MUL,    R_T0,  R_WR,  R_X,   B_REG,    6'd0);
         6'd16: u = mk(OP_MUL,    R_T1,  R_WI,  R_Y,   B_REG,    6'd0);
         6'd17: u = mk(OP_SUB,    R_NR,  R_T0,  R_T1,  B_REG,    6'd0);
         6'd18: u = mk(OP_MUL,    R_T0,  R_WR,  R_Y,   B_REG,    6'd0);
         6'd19: u = mk(OP_MUL,    R_T1,  R_WI,  R_X,   B_REG,    6'd0);
         6'd20: u = mk(OP_ADD,    R_NI,  R_T0,  R_T1,  B_REG,    6'd0);
         6'd21: u = mk(OP_DBL1,   R_NR,  R_NR,  R_NR,  B_REG,    6'd0);
         6'd22: u = mk(OP_ADD,    R_NI,  R_NI,  R_NI,  B_REG,    6'd0);
         6'd23: u = mk(OP_TRI,    R_DR,  R_WR,  R_WR,  B_REG,    6'd0);
         6'd24: u = mk(OP_TRI,    R_DI,  R_WI,  R_WI,  B_REG,    6'd0);
         6'd25: u = mk(OP_BRANCH, R_DR,  R_DR,  R_DI,  B_REG,    PC_SMALL);
         6'd26: u = mk(OP_DIV,    R_R,   R_DI,  R_DR,  B_REG,    6'd0);
         6'd27: u = mk(OP_MUL,    R_T0,  R_DI,  R_R,   B_REG,    6'd0);
         6'd28: u = mk(OP_ADD,    R_DEN, R_DR,  R_T0,  B_REG,    6'd0);
         6'd29: u = mk(OP_MUL,    R_T0,  R_NI,  R_R,   B_REG,    6'd0);
         6'd30: u = mk(OP_ADD,    R_T0,  R_NR,  R_T0,  B_REG,    6'd0);
         6'd31: u = mk(OP_MUL,    R_T1,  R_NR,  R_R,   B_REG,    6'd0);
         6'd32: u = mk(OP_SUB,    R_T1,  R_NI,  R_T1,  B_REG,    6'd0);
         6'd33: u = mk(OP_DIV,    R_X,   R_T0,  R_DEN, B_REG,    6'd0);
         6'd34: u = mk(OP_DIV,    R_Y,   R_T1,  R_DEN, B_REG,    6'd0);
         6'd35: u = mk(OP_SUB,    R_T0,  R_X,   R_OX,  B_REG,    6'd0);
         6'd36: u = mk(OP_SUB,    R_T1,  R_Y,   R_OY,  B_REG,    6'd0);
         6'd37: u = mk(OP_MUL,    R_T0,  R_T0,  R_T0,  B_REG,    6'd0);
         6'd38: u = mk(OP_MUL,    R_T1,  R_T1,  R_T1,  B_REG,    6'd0);
         6'd39: u = mk(OP_ADD,    R_S,   R_T0,  R_T1,  B_REG,    6'd0);
         6'd40: u = mk(OP_JUMP,   R_X,   R_X,   R_X,   B_REG,    PC_LOOP);
         6'd41: u = mk(OP_DIV,    R_R,   R_DR,  R_DI,  B_REG,    6'd0);
         6'd42: u = mk(OP_MUL,    R_T0,  R_DR,  R_R,   B_REG,    6'd0);
         6'd43: u = mk(OP_ADD,    R_DEN, R_DI,  R_T0,  B_REG,    6'd0);
         6'd44: u = mk(OP_MUL,    R_T0,  R_NR,  R_R,   B_REG,    6'd0);
         6'd45: u = mk(OP_ADD,    R_T0,  R_T0,  R_NI,  B_REG,    6'd0);
         6'd46: u = mk(OP_MUL,    R_T1,  R_NI,  R_R,   B_REG,    6'd0);
         6'd47: u = mk(OP_SUB,    R_T1,  R_T1,  R_NR,  B_REG,    6'd0);
         6'd48: u = mk(OP_JUMP,   R_X,   R_X,   R_X,   B_REG,    PC_TAIL);
         6'd49: u = mk(OP_COLOR,  R_X,   R_X,   R_Y,   B_REG,    6'd0);
         default: u = mk(OP_JUMP, R_X,   R_X,   R_X,   B_REG,    PC_COLOR);
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

### sv/newton_fractal_pixel.sv
// Newton fractal pixel for z^3 - 1 in signed Q8.24. One pixel word in gives one word out
// (24-bit color, final iteration count). A small microcoded sequencer drives one shared
// 33x33 multiplier/adder and one divider that yields two quotient bits a cycle; the divider
// sets the pace. The view mapping comes first, then each Newton iteration (three divides
// and 28 arithmetic operations), then the color. The block takes no new pixel while one is in
// flight; a finished word waits in the output register while the next pixel is taken.
`default_nettype none

module newton_fractal_pixel
   import nfp_pkg::*;
#(
   parameter int IMG_WIDTH  = 1024,
   parameter int IMG_HEIGHT = 1024
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      rsp_type     rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_FETCH  = 7'b0000010,
      ST_EXEC   = 7'b0000100,
      ST_DLOAD  = 7'b0001000,
      ST_DIVIDE = 7'b0010000,
      ST_WRITE  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      CSR_HALF_SPAN, CSR_ZOOM, CSR_ASPECT, CSR_MOVE_X, CSR_MOVE_Y, CSR_TOL, CSR_MAX_ITER
   } csr_type;

   logic [30:0]        hs_ff, zoom_ff, aspect_ff, tol_ff;
   logic signed [31:0] movex_ff, movey_ff;
   logic [7:0]         maxit_ff;

   state_type          state_ff, state_in;
   logic [5:0]         pc_ff, pc_in;
   logic [7:0]         i_ff, i_in;
   logic signed [31:0] step_ff, step_in;
   logic               stuck_ff, stuck_in;
   logic [9:0]         px_ff, px_in, py_ff, py_in;
   logic signed [31:0] rda_ff, rdb_ff;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [31:0] res_ff, res_in;
   logic               neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic signed [31:0] rf_ff [16];

   uop_type            u;
   logic signed [31:0] bval;
   logic signed [32:0] mul_a, mul_b;
   logic signed [31:0] wr_val;
   logic               wr_en;
   logic [23:0]        color;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   nfp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign u = ucode(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff     <= 31'd33554432;
         zoom_ff   <= 31'd16777216;
         aspect_ff <= 31'd16777216;
         movex_ff  <= '0;
         movey_ff  <= '0;
         tol_ff    <= 31'd16777;
         maxit_ff  <= 8'd50;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HALF_SPAN: hs_ff     <= csr_wdata[30:0];
            CSR_ZOOM:      zoom_ff   <= csr_wdata[30:0];
            CSR_ASPECT:    aspect_ff <= csr_wdata[30:0];
            CSR_MOVE_X:    movex_ff  <= signed'(csr_wdata);
            CSR_MOVE_Y:    movey_ff  <= signed'(csr_wdata);
            CSR_TOL:       tol_ff    <= csr_wdata[30:0];
            CSR_MAX_ITER:  maxit_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (u.bsel)
         B_REG:    bval = rdb_ff;
         B_ZERO:   bval = '0;
         B_ZOOM:   bval = signed'({1'b0, zoom_ff});
         B_ASPECT: bval = signed'({1'b0, aspect_ff});
         B_MOVEX:  bval = movex_ff;
         B_MOVEY:  bval = movey_ff;
         default:  bval = '0;
      endcase
   end

   // shared multiplier and adder operands
   always_comb begin
      unique case (u.op)
         OP_MAPX: begin
            mul_a = signed'({2'b00, hs_ff});
            mul_b = signed'({23'd0, px_ff});
         end
         OP_MAPY: begin
            mul_a = signed'({2'b00, hs_ff});
            mul_b = signed'({23'd0, py_ff});
         end
         OP_COLOR: begin
            mul_a = signed'({9'd0, COLOR_MID});
            mul_b = signed'({25'd0, i_ff});
         end
         default: begin
            mul_a = 33'(rda_ff);
            mul_b = 33'(bval);
         end
      endcase
      prod_in = mul_a * mul_b;
      unique case (u.op)
         OP_ADD:  res_in = sat(66'(rda_ff) + 66'(bval));
         OP_SUB:  res_in = sat(66'(rda_ff) - 66'(bval));
         OP_DBL1: res_in = sat(66'(rda_ff) + 66'(rda_ff) + 66'(signed'({1'b0, Q_ONE})));
         OP_TRI:  res_in = sat(66'(rda_ff) + 66'(rda_ff) + 66'(rda_ff));
         default: res_in = res_ff;
      endcase
   end

   // divider feed: Q8.24 quotient in EXEC, mapping and color scale in DLOAD
   always_comb begin
      logic [31:0] mag_a, mag_b;
      mag_a = rda_ff[31] ? 32'(-rda_ff) : 32'(rda_ff);
      mag_b = bval[31] ? 32'(-bval) : 32'(bval);
      div_req = '0;
      if (state_ff == ST_EXEC && u.op == OP_DIV) begin
         div_req.start    = 1'b1;
         div_req.dividend = {mag_a, 24'd0};
         div_req.divisor  = mag_b;
      end else if (state_ff == ST_DLOAD) begin
         div_req.start = 1'b1;
         unique case (u.op)
            OP_MAPX: begin
               div_req.dividend = {prod_ff[54:0], 1'b0};
               div_req.divisor  = 32'(IMG_WIDTH);
            end
            OP_MAPY: begin
               div_req.dividend = {prod_ff[54:0], 1'b0};
               div_req.divisor  = 32'(IMG_HEIGHT);
            end
            default: begin
               div_req.dividend = prod_ff[DVD_W-1:0];
               div_req.divisor  = MID_DIV;
            end
         endcase
      end
   end

   // writeback value
   always_comb begin
      logic signed [65:0] mt, qs, hs66;
      logic [DVD_W-1:0]   qd;
      qd   = div_rsp.quotient;
      qs   = signed'({10'd0, qd});
      hs66 = signed'({35'd0, hs_ff});
      mt   = prod_ff + (prod_ff[65] ? 66'sd16777215 : 66'sd0);
      wr_en = 1'b1;
      unique case (u.op)
         OP_MUL:  wr_val = sat(mt >>> 24);
         OP_DIV: begin
            if (neg_ff)
               wr_val = (qd > DVD_W'(32'h8000_0000)) ? S32_MIN : signed'(-qd[31:0]);
            else
               wr_val = (qd > DVD_W'(32'h7FFF_FFFF)) ? S32_MAX : signed'(qd[31:0]);
         end
         OP_MAPX: wr_val = sat(qs - hs66);
         OP_MAPY: wr_val = sat(hs66 - qs);
         OP_ADD, OP_SUB, OP_DBL1, OP_TRI: wr_val = res_ff;
         default: begin
            wr_val = res_ff;
            wr_en  = 1'b0;
         end
      endcase
   end

   always_comb begin
      logic signed [33:0] xs, ts;
      xs = 34'(rda_ff);
      ts = signed'({3'b000, tol_ff});
      priority if (stuck_ff || i_ff == maxit_ff)
         color = COLOR_RED;
      else if (xs <= -ts)
         color = COLOR_NEG + 24'({i_ff, 8'h00});
      else if (xs >= ts && rdb_ff > 32'sd0)
         color = COLOR_PP + 24'({i_ff, 8'h00});
      else if (xs >= ts && rdb_ff < 32'sd0)
         color = COLOR_PN + 24'({i_ff, 8'h00});
      else
         color = div_rsp.quotient[23:0];
   end

   // sequencer
   always_comb begin
      logic [31:0] mag_r, mag_i;
      mag_r = rda_ff[31] ? 32'(-rda_ff) : 32'(rda_ff);
      mag_i = rdb_ff[31] ? 32'(-rdb_ff) : 32'(rdb_ff);
      state_in     = state_ff;
      pc_in        = pc_ff;
      i_in         = i_ff;
      step_in      = step_ff;
      stuck_in     = stuck_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      neg_in       = neg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               px_in    = req_data.px_x;
               py_in    = req_data.px_y;
               pc_in    = '0;
               i_in     = 8'd1;
               step_in  = signed'(Q_ONE);
               stuck_in = 1'b0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            unique case (u.op)
               OP_CHECK: begin
                  if (34'(step_ff) > signed'({3'b000, tol_ff}) && i_ff < maxit_ff) begin
                     i_in  = i_ff + 1'b1;
                     pc_in = pc_ff + 1'b1;
                  end else begin
                     pc_in = u.target;
                  end
               end
               OP_JUMP: pc_in = u.target;
               default: state_in = ST_EXEC;
            endcase
         end
         ST_EXEC: begin
            unique case (u.op)
               OP_BRANCH: begin
                  state_in = ST_FETCH;
                  if (rda_ff == 32'sd0 && rdb_ff == 32'sd0) begin
                     stuck_in = 1'b1;
                     pc_in    = PC_COLOR;
                  end else if (mag_r >= mag_i) begin
                     pc_in = pc_ff + 1'b1;
                  end else begin
                     pc_in = u.target;
                  end
               end
               OP_DIV: begin
                  neg_in   = rda_ff[31] ^ bval[31];
                  state_in = ST_DIVIDE;
               end
               OP_MAPX, OP_MAPY, OP_COLOR: state_in = ST_DLOAD;
               default: state_in = ST_WRITE;
            endcase
         end
         ST_DLOAD: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_rsp.done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (u.op == OP_COLOR) begin
               state_in = ST_DONE;
            end else begin
               if (u.dst == R_S) step_in = wr_val;
               pc_in    = pc_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.color      = color;
               rsp_data_in.iterations = i_ff;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE && wr_en) rf_ff[u.dst] <= wr_val;
      if (state_ff == ST_FETCH) begin
         rda_ff <= rf_ff[u.a];
         rdb_ff <= rf_ff[u.b];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         prod_ff <= prod_in;
         res_ff  <= res_in;
      end
      i_ff        <= i_in;
      step_ff     <= step_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         stuck_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         stuck_ff     <= stuck_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### sv/nfp_div.sv
`default_nettype none

module nfp_div
   import nfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output      div_rsp_type rsp
);

   localparam int unsigned STEPS = DVD_W / 2;
   localparam int unsigned CNT_W = $clog2(STEPS);

   logic [DVD_W-1:0] q_ff, q_in;
   logic [32:0]      rem_ff, rem_in;
   logic [31:0]      dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // restoring division, two quotient bits a cycle
   always_comb begin
      logic [32:0]      r;
      logic [DVD_W-1:0] q;
      r = rem_ff;
      q = q_ff;
      for (int k = 0; k < 2; k++) begin
         r = {r[31:0], q[DVD_W-1]};
         q = {q[DVD_W-2:0], 1'b0};
         if (r >= {1'b0, dvs_ff}) begin
            r    = r - {1'b0, dvs_ff};
            q[0] = 1'b1;
         end
      end
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         q_in    = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = q;
         rem_in = r;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff;

endmodule

`default_nettype wire
